// ----- rtl/bbc_pkg.sv -----
// types, constants and character decoders shared by the bracket checker
`default_nettype none

package bbc_pkg;

   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [1:0]        kind_type;
   typedef logic [2:0]        fault_type;

   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_NONE   = 2'd3;

   localparam fault_type FAULT_NONE        = 3'd0;
   localparam fault_type FAULT_EMPTY_CLOSE = 3'd1;
   localparam fault_type FAULT_WRONG_KIND  = 3'd2;
   localparam fault_type FAULT_LEFT_OPEN   = 3'd3;
   localparam fault_type FAULT_TOO_DEEP    = 3'd4;

   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } char_type;

   typedef struct packed {
      logic      balanced;
      fault_type fault_kind;
   } verdict_type;

   function automatic kind_type open_kind(input logic [7:0] code);
      kind_type kind;
      unique case (code)
         CHAR_OPEN_ROUND:  kind = KIND_ROUND;
         CHAR_OPEN_SQUARE: kind = KIND_SQUARE;
         CHAR_OPEN_CURLY:  kind = KIND_CURLY;
         default:          kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   function automatic kind_type close_kind(input logic [7:0] code);
      kind_type kind;
      unique case (code)
         CHAR_CLOSE_ROUND:  kind = KIND_ROUND;
         CHAR_CLOSE_SQUARE: kind = KIND_SQUARE;
         CHAR_CLOSE_CURLY:  kind = KIND_CURLY;
         default:           kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bbc_if.sv -----
// valid/ready channel interfaces for characters in and verdicts out
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       balanced;
   logic [2:0] fault_kind;

   modport source (output valid, output balanced, output fault_kind, input ready);
   modport sink   (input valid, input balanced, input fault_kind, output ready);
endinterface

`default_nettype wire

// ----- rtl/bbc_core.sv -----
// bracket stack in a synchronous memory with top and second entries held in registers
`default_nettype none

module bbc_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_valid,
   input  wire bbc_pkg::char_type    step_char,
   output logic                      verdict_valid,
   output bbc_pkg::verdict_type      verdict
);
   import bbc_pkg::*;

   kind_type  stack_mem [STACK_DEPTH];

   count_type count_ff;
   count_type count_in;
   count_type count_step;
   fault_type fault_ff;
   fault_type fault_in;
   fault_type fault_step;
   fault_type fault_final;
   kind_type  top_ff;
   kind_type  top_in;
   kind_type  below_ff;
   kind_type  ok_kind;
   kind_type  ck_kind;
   logic      push;
   logic      wr_en;
   addr_type  wr_addr;
   addr_type  rd_addr;

   always_comb begin
      ok_kind    = open_kind(step_char.char_code);
      ck_kind    = close_kind(step_char.char_code);
      fault_step = fault_ff;
      count_step = count_ff;
      top_in     = top_ff;
      push       = 1'b0;
      if (step_valid && fault_ff == FAULT_NONE) begin
         if (ok_kind != KIND_NONE) begin
            if (count_ff == count_type'(STACK_DEPTH)) begin
               fault_step = FAULT_TOO_DEEP;
            end else begin
               push       = 1'b1;
               count_step = count_ff + count_type'(1);
               top_in     = ok_kind;
            end
         end else if (ck_kind != KIND_NONE) begin
            if (count_ff == '0) begin
               fault_step = FAULT_EMPTY_CLOSE;
            end else if (top_ff != ck_kind) begin
               fault_step = FAULT_WRONG_KIND;
            end else begin
               count_step = count_ff - count_type'(1);
               top_in     = below_ff;
            end
         end
      end

      verdict_valid = step_valid && step_char.last_char;
      if (fault_step == FAULT_NONE && count_step != '0) begin
         fault_final = FAULT_LEFT_OPEN;
      end else begin
         fault_final = fault_step;
      end
      verdict.fault_kind = fault_final;
      verdict.balanced   = (fault_final == FAULT_NONE);

      count_in = verdict_valid ? '0 : count_step;
      fault_in = verdict_valid ? FAULT_NONE : fault_step;

      // old top spills into memory; prefetch the entry under the next top
      wr_en   = push && (count_ff != '0);
      wr_addr = addr_type'(count_ff - count_type'(1));
      rd_addr = addr_type'(count_in - count_type'(2));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      if (wr_en && wr_addr == rd_addr) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fault_ff <= FAULT_NONE;
      end else begin
         count_ff <= count_in;
         fault_ff <= fault_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_fault_sticky : assert property (@(posedge clock) disable iff (reset)
      (step_valid && !step_char.last_char && fault_ff != FAULT_NONE)
      |=> (fault_ff == $past(fault_ff) && count_ff == $past(count_ff)))
      else $error("fault state changed after first fault");

   a_clear_on_last : assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_char.last_char) |=> (count_ff == '0 && fault_ff == FAULT_NONE))
      else $error("string state not cleared after last character");

endmodule

`default_nettype wire

// ----- rtl/bracket_balance_checker_unit.sv -----
// bracket balance checker top level with registered verdict output and skid stage
//
// req_chan carries one character per transaction (char_code, last_char set on
// the final character of a string). Opening ( [ { push onto a stack held in
// a one-port-write, one-port-read synchronous memory; the matching close pops
// it. The first fault of a string sticks until its last character.
// rsp_chan carries one verdict (balanced, fault_kind) per string; it is
// registered in the output register when the last character is accepted, or in
// the skid register while rsp_chan is stalled. Throughput is one character per
// cycle while req_chan.ready is high: the top of stack and the entry below it
// live in registers, and the memory read of the next entry below is issued from
// the next stack count, with the pushed value forwarded when addresses match.
// A second result register lets one more string finish while rsp_chan is
// stalled; req_chan.ready drops only when both result registers hold verdicts.
// Reset is synchronous and active high; it empties the stack, clears the fault,
// drops both result registers and leaves req_chan.ready high once released.
`default_nettype none

module bracket_balance_checker_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   bbc_req_if.sink    req_chan,
   bbc_rsp_if.source  rsp_chan
);
   import bbc_pkg::*;

   logic        accept;
   char_type    step_char;
   logic        verdict_valid;
   verdict_type verdict;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   verdict_type out_ff;
   verdict_type out_in;
   verdict_type skid_ff;
   verdict_type skid_in;

   assign req_chan.ready      = !skid_valid_ff;
   assign accept              = req_chan.valid && !skid_valid_ff;
   assign step_char.char_code = req_chan.char_code;
   assign step_char.last_char = req_chan.last_char;

   bbc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (accept),
      .step_char     (step_char),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = verdict_valid;
            out_in       = verdict;
         end
      end else if (verdict_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.balanced   = out_ff.balanced;
   assign rsp_chan.fault_kind = out_ff.fault_kind;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a verdict ahead of the output register");

   a_verdict_consistent : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.balanced == (out_ff.fault_kind == FAULT_NONE)))
      else $error("balanced flag disagrees with fault kind");

endmodule

`default_nettype wire

// ----- tb/sv/bracket_balance_checker_unit_test.sv -----
// testbench for the bracket balance checker: directed and random strings checked by a predictor
`timescale 1ns / 100ps

module bracket_balance_checker_unit_test;
   import bbc_pkg::*;

   logic clock;
   logic reset;

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   bracket_balance_checker_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [7:0]  open_chars  [0:2] = '{CHAR_OPEN_ROUND, CHAR_OPEN_SQUARE, CHAR_OPEN_CURLY};
   logic [7:0]  close_chars [0:2] = '{CHAR_CLOSE_ROUND, CHAR_CLOSE_SQUARE, CHAR_CLOSE_CURLY};

   kind_type    stack_kinds [STACK_DEPTH];
   int unsigned open_depth;
   fault_type   sticky_fault;
   verdict_type pending_verdicts [$];
   logic [7:0]  text_buf [$];

   int unsigned mismatch_count;
   int unsigned counted_items;
   bit          req_idling_on;
   bit          rsp_idling_on;
   int unsigned rsp_hold_cycles;
   int unsigned rsp_stall_left;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic kind_type bracket_kind(input logic [7:0] code);
      case (code)
         CHAR_OPEN_ROUND,  CHAR_CLOSE_ROUND:  return KIND_ROUND;
         CHAR_OPEN_SQUARE, CHAR_CLOSE_SQUARE: return KIND_SQUARE;
         CHAR_OPEN_CURLY,  CHAR_CLOSE_CURLY:  return KIND_CURLY;
         default:                             return KIND_NONE;
      endcase
   endfunction

   function automatic void track_char(input logic [7:0] code, input logic last);
      verdict_type verdict;
      kind_type    kind;
      kind = bracket_kind(code);
      if (sticky_fault == FAULT_NONE && kind != KIND_NONE) begin
         if (code == open_chars[kind]) begin
            if (open_depth == STACK_DEPTH) begin
               sticky_fault = FAULT_TOO_DEEP;
            end else begin
               stack_kinds[open_depth] = kind;
               open_depth++;
            end
         end else if (open_depth == 0) begin
            sticky_fault = FAULT_EMPTY_CLOSE;
         end else if (stack_kinds[open_depth - 1] != kind) begin
            sticky_fault = FAULT_WRONG_KIND;
         end else begin
            open_depth--;
         end
      end
      if (last) begin
         verdict.fault_kind = sticky_fault;
         if (sticky_fault == FAULT_NONE && open_depth != 0)
            verdict.fault_kind = FAULT_LEFT_OPEN;
         verdict.balanced = (verdict.fault_kind == FAULT_NONE);
         pending_verdicts.push_back(verdict);
         open_depth   = 0;
         sticky_fault = FAULT_NONE;
      end
   endfunction

   task automatic send_char(input logic [7:0] code, input logic last);
      if (req_idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= code;
      req_chan.last_char <= last;
      do @(posedge clock); while (!req_chan.ready);
      track_char(code, last);
      counted_items++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_text(input string text);
      text_buf.delete();
      for (int i = 0; i < text.len(); i++)
         text_buf.push_back(text[i]);
      send_buffer();
   endtask

   task automatic wait_for_verdicts();
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed strings, some nested near the stack limit, some corrupted
   task automatic fill_random_text();
      int          open_kinds [$];
      int unsigned remaining;
      int unsigned pick;
      int unsigned kind;
      int unsigned spot;
      logic [7:0]  code;
      text_buf.delete();
      if ($urandom_range(0, 39) == 0) begin
         repeat ($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2)) begin
            kind = $urandom_range(0, 2);
            open_kinds.push_back(kind);
            text_buf.push_back(open_chars[kind]);
         end
         while (open_kinds.size() != 0)
            text_buf.push_back(close_chars[open_kinds.pop_back()]);
      end else begin
         remaining = $urandom_range(1, 16);
         while (remaining != 0) begin
            pick = $urandom_range(0, 99);
            if (open_kinds.size() != 0 && (remaining <= open_kinds.size() || pick < 35)) begin
               text_buf.push_back(close_chars[open_kinds.pop_back()]);
            end else if (remaining >= open_kinds.size() + 2 && pick < 75) begin
               kind = $urandom_range(0, 2);
               open_kinds.push_back(kind);
               text_buf.push_back(open_chars[kind]);
            end else begin
               code = 8'($urandom_range(0, 255));
               if (bracket_kind(code) != KIND_NONE)
                  code ^= 8'h80;
               text_buf.push_back(code);
            end
            remaining--;
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            spot = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 2))
               0:       text_buf[spot] = open_chars[$urandom_range(0, 2)];
               1:       text_buf[spot] = close_chars[$urandom_range(0, 2)];
               default: text_buf[spot] = 8'($urandom_range(0, 255));
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_cycles != 0) begin
         rsp_chan.ready  <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (rsp_stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_idling_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      verdict_type expected;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: verdict with none pending, balanced %b fault_kind %0d",
                     $time, rsp_chan.balanced, rsp_chan.fault_kind);
            mismatch_count++;
         end else begin
            expected = pending_verdicts.pop_front();
            if (rsp_chan.balanced !== expected.balanced) begin
               $display("%0t ns: balanced expected %b actual %b",
                        $time, expected.balanced, rsp_chan.balanced);
               mismatch_count++;
            end
            if (rsp_chan.fault_kind !== expected.fault_kind) begin
               $display("%0t ns: fault_kind expected %0d actual %0d",
                        $time, expected.fault_kind, rsp_chan.fault_kind);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_directed_strings();
      send_text("()");
      send_char(8'h00, 1'b1);
      send_char(8'hff, 1'b1);
      send_char(CHAR_OPEN_SQUARE, 1'b0);
      send_char(CHAR_OPEN_CURLY, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(CHAR_CLOSE_CURLY, 1'b0);
      send_char(CHAR_CLOSE_SQUARE, 1'b1);
      send_text(")");
      send_text("(]");
      send_text("{");
      send_text("})");
      send_text("(]{");
      send_text("[)");
      send_text("((x");
   endtask

   task automatic test_stack_limit();
      text_buf.delete();
      for (int i = 0; i < STACK_DEPTH; i++)
         text_buf.push_back(open_chars[i % 3]);
      for (int i = STACK_DEPTH - 1; i >= 0; i--)
         text_buf.push_back(close_chars[i % 3]);
      send_buffer();
      text_buf.delete();
      for (int i = 0; i <= STACK_DEPTH; i++)
         text_buf.push_back(open_chars[i % 3]);
      text_buf.push_back(CHAR_CLOSE_ROUND);
      send_buffer();
   endtask

   task automatic test_random_strings(input int unsigned item_goal);
      int unsigned goal_mark;
      goal_mark     = counted_items + item_goal;
      req_idling_on = 1'b1;
      rsp_idling_on <= 1'b1;
      while (counted_items < goal_mark) begin
         if ($urandom_range(0, 7) == 0)
            req_idling_on = !req_idling_on;
         if ($urandom_range(0, 7) == 0)
            rsp_idling_on <= !rsp_idling_on;
         fill_random_text();
         send_buffer();
      end
   endtask

   // receiver stalls long enough for both result registers to fill and block input
   task automatic test_receiver_hold();
      req_idling_on = 1'b0;
      rsp_hold_cycles <= 300;
      repeat (12) begin
         fill_random_text();
         send_buffer();
      end
      wait_for_verdicts();
   endtask

   task automatic test_steady_stream(input int unsigned item_goal);
      int unsigned goal_mark;
      goal_mark     = counted_items + item_goal;
      req_idling_on = 1'b0;
      rsp_idling_on <= 1'b0;
      while (counted_items < goal_mark) begin
         fill_random_text();
         send_buffer();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = 8'h00;
      req_chan.last_char = 1'b0;
      rsp_chan.ready     = 1'b0;
      open_depth         = 0;
      sticky_fault       = FAULT_NONE;
      mismatch_count     = 0;
      counted_items      = 0;
      req_idling_on      = 1'b0;
      rsp_idling_on      = 1'b0;
      rsp_hold_cycles    = 0;
      rsp_stall_left     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_stack_limit();
      test_random_strings(450);
      test_receiver_hold();
      test_steady_stream(240);
      wait_for_verdicts();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
